### src/leg_ik_servo_targets_unit_defines.svh
// Assertion macros for the leg IK servo target unit.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef LEG_IK_SERVO_TARGETS_UNIT_DEFINES_SVH
`define LEG_IK_SERVO_TARGETS_UNIT_DEFINES_SVH

// holds at every clock edge outside reset
`define LIK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// pre in one cycle implies post in the next
`define LIK_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### src/lik_pkg.sv
// Shared constants, types and functions of the leg IK servo target unit.
// No dependencies.
`default_nettype none
package lik_pkg;

  localparam int unsigned JOINTS            = 12;
  localparam int unsigned CORDIC_ITERATIONS = 16;
  localparam int unsigned ANGLE_BITS        = 16;
  localparam int unsigned COUNT_BITS        = 12;
  localparam int unsigned COORD_BITS        = 15;
  localparam int unsigned OPND_BITS         = 18;
  localparam int unsigned SQ_RAD_BITS       = 32;
  localparam int unsigned SQ_ROOT_BITS      = 16;
  localparam int unsigned CFG_IDX_BITS      = 2;
  localparam int unsigned CFG_DATA_BITS     = 12;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LEG_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIFT_OFFSET = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_YAW_POS     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH_POS   = 2'd3;

  localparam logic [9:0]            LEG_LENGTH_RST  = 10'd180;
  localparam logic [7:0]            LIFT_OFFSET_RST = 8'd20;
  localparam logic [COUNT_BITS-1:0] HEAD_RST        = 12'd512;
  localparam logic [COUNT_BITS-1:0] LEG_REST_COUNT  = 12'd2048;

  localparam logic [31:0] ATAN_TABLE [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // atan(2^-idx) in binary angles of the given width, rounded
  function automatic logic [31:0] step_angle(input int unsigned idx,
                                             input int unsigned bits);
    logic [32:0] sum;
    int unsigned sh;
    sh  = 32 - bits;
    sum = {1'b0, ATAN_TABLE[idx]} + (33'd1 << (sh - 1));
    return 32'(sum >> sh);
  endfunction

endpackage
`default_nettype wire

### src/lik_if.sv
// Valid/ready channel interfaces for foot targets and servo results.
// Uses lik_pkg for field widths.
`default_nettype none
interface lik_in_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [lik_pkg::COORD_BITS-1:0]       x_pos;
  logic signed [lik_pkg::COORD_BITS-1:0]       y_pos;
  logic signed [lik_pkg::COORD_BITS-1:0]       z_pos;
  modport source (output valid, x_pos, y_pos, z_pos, input ready);
  modport sink (input valid, x_pos, y_pos, z_pos, output ready);
endinterface

interface lik_out_if;
  logic                              valid;
  logic                              ready;
  logic [3:0]                        joint_index;
  logic [lik_pkg::COUNT_BITS-1:0]    position;
  logic                              range_error;
  logic                              last;
  modport source (output valid, joint_index, position, range_error, last, input ready);
  modport sink (input valid, joint_index, position, range_error, last, output ready);
endinterface
`default_nettype wire

### src/lik_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Uses lik_pkg for radicand and root widths.
`default_nettype none
module lik_isqrt (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [lik_pkg::SQ_RAD_BITS-1:0]  radicand_i,
  output logic                                  done_o,
  output logic [lik_pkg::SQ_ROOT_BITS-1:0]      root_o
);
  localparam int unsigned RW = lik_pkg::SQ_ROOT_BITS;
  localparam int unsigned NW = lik_pkg::SQ_RAD_BITS;
  localparam int unsigned IW = $clog2(RW);

  logic          busy_q, done_q;
  logic [IW-1:0] it_q;
  logic [NW-1:0] rad_q;
  logic [RW:0]   rem_q;
  logic [RW+2:0] rem_n, trial;
  logic [RW-1:0] root_q;

  assign rem_n = {rem_q, rad_q[NW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        if (it_q == IW'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          it_q <= it_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (rem_n >= trial) begin
        rem_q  <= (RW+1)'(rem_n - trial);
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n[RW:0];
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

### src/lik_cordic.sv
// Iterative vectoring CORDIC atan2 in binary angles, one micro-rotation per cycle.
// Uses lik_pkg for the arctangent table and operand width.
`default_nettype none
module lik_cordic #(
  parameter int unsigned ITERATIONS = lik_pkg::CORDIC_ITERATIONS,
  parameter int unsigned ANGLE_BITS = lik_pkg::ANGLE_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [lik_pkg::OPND_BITS-1:0] y_i,
  input  wire logic signed [lik_pkg::OPND_BITS-1:0] x_i,
  output logic                                     done_o,
  output logic [ANGLE_BITS-1:0]                    angle_o
);
  localparam int unsigned OW = lik_pkg::OPND_BITS;
  localparam int unsigned CW = OW + 12;
  localparam int unsigned IW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
  localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  logic                  busy_q, done_q;
  logic [IW-1:0]         it_q;
  logic signed [CW-1:0]  xv_q, yv_q, xs, ys, x_ext, y_ext;
  logic [ANGLE_BITS-1:0] ang_q, step;

  assign x_ext = {{(CW-OW){x_i[OW-1]}}, x_i} <<< 8;
  assign y_ext = {{(CW-OW){y_i[OW-1]}}, y_i} <<< 8;
  assign xs    = xv_q >>> it_q;
  assign ys    = yv_q >>> it_q;
  assign step  = ANGLE_BITS'(lik_pkg::step_angle(int'(it_q), ANGLE_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        it_q <= '0;
        if (x_i == '0 && y_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (it_q == IW'(ITERATIONS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          it_q <= it_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i == '0 && y_i == '0) begin
        ang_q <= '0;
      end else if (x_i[OW-1]) begin
        xv_q  <= -x_ext;
        yv_q  <= -y_ext;
        ang_q <= HALF;
      end else begin
        xv_q  <= x_ext;
        yv_q  <= y_ext;
        ang_q <= '0;
      end
    end else if (busy_q) begin
      if (!yv_q[CW-1]) begin
        xv_q  <= xv_q + ys;
        yv_q  <= yv_q - xs;
        ang_q <= ang_q + step;
      end else begin
        xv_q  <= xv_q - ys;
        yv_q  <= yv_q + xs;
        ang_q <= ang_q - step;
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;
endmodule
`default_nettype wire

### src/leg_ik_servo_targets_unit.sv
// Leg IK servo target unit: sequencer, shared multiplier and result store.
// Depends on lik_pkg, lik_if, lik_isqrt, lik_cordic and the assertion macro header.
//
// Usage:
// - in_i takes one foot target (x_pos, y_pos, z_pos, 1/16 mm) per transaction;
//   ready is high only while the unit is idle.
// - out_o then gives twelve transactions, joints 0..11, last set on joint 11,
//   or a single transaction with range_error and last set if out of reach.
// - Sequence: the reach test, then (unless out of reach) per pose up to two square
//   roots and up to four atan2 evaluations (three for the offset pose) on the one
//   shared CORDIC unit; then one result per cycle while out_o is ready.
// - A stalled receiver holds the current result; no new target is taken
//   until the last result has been taken.
// - Reset: registers take 180 mm, 20 mm, 512, 512; stored joint positions
//   take 2048 for the legs and 512 for the head. No clearing pass.
// - cfg_we_i writes register cfg_index_i with cfg_data_i; write only when idle.
`default_nettype none
module leg_ik_servo_targets_unit #(
  parameter int unsigned CORDIC_ITERATIONS = lik_pkg::CORDIC_ITERATIONS,
  parameter int unsigned ANGLE_BITS        = lik_pkg::ANGLE_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lik_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [lik_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  lik_in_if.sink                                  in_i,
  lik_out_if.source                               out_o
);
  localparam int unsigned AB    = ANGLE_BITS;
  localparam int unsigned CB    = lik_pkg::COUNT_BITS;
  localparam int unsigned OW    = lik_pkg::OPND_BITS;
  localparam int unsigned CNT_W = $clog2(lik_pkg::JOINTS);
  localparam logic [AB-1:0] HALF    = AB'(1) << (AB - 1);
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_SQL, ST_CHECK,
    ST_H2, ST_X2, ST_SQRTD, ST_D2, ST_SQRTR, ST_ATHP2,
    ST_AT1, ST_AT2, ST_AT3, ST_WRITE, ST_OUT
  } state_e;

  state_e state_q;
  logic   pass_q, err_q, launched_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CB-1:0]    stored_q [lik_pkg::JOINTS];

  logic [9:0]    leg_q;
  logic [7:0]    lift_q;
  logic [CB-1:0] yaw_q, pitch_q;

  logic signed [lik_pkg::COORD_BITS-1:0] x_q, y_q, z_q;
  logic [33:0] acc_q;
  logic [29:0] l2sq_q;
  logic [15:0] d_q, r_q;
  logic [AB-1:0] hp2_q, a1_q, thp_q, tap_q, tro_q, ihp_q, iap_q, iro_q;

  logic [14:0]        l2;
  logic [11:0]        off;
  logic signed [16:0] zz_t, zz_cur;
  logic signed [OW-1:0] h_cur, ah, x_cur, y_cur, mul_a;
  logic signed [2*OW-1:0] prod;
  logic [33:0] prod_u;
  logic in_acc, out_acc, out_last;

  logic sq_start, sq_done, cord_start, cord_done;
  logic [lik_pkg::SQ_RAD_BITS-1:0] sq_rad;
  logic [15:0] sq_root;
  logic signed [OW-1:0] cord_y, cord_x;
  logic [AB-1:0] cord_ang;

  logic [AB-1:0] l_hp, l_ap, r_hp, r_ap, roll, c0, c1, c2, c6, c7;
  logic          y_neg, y_zero;

  assign l2     = {leg_q, 5'b0};
  assign off    = {lift_q, 4'b0};
  assign zz_t   = $signed({{2{z_q[14]}}, z_q}) + $signed({5'b0, off});
  assign zz_cur = pass_q ? $signed({5'b0, off}) : zz_t;
  assign h_cur  = $signed({3'b0, l2}) - $signed({zz_cur[16], zz_cur});
  assign ah     = h_cur[OW-1] ? -h_cur : h_cur;
  assign x_cur  = pass_q ? '0 : {{(OW-15){x_q[14]}}, x_q};
  assign y_cur  = pass_q ? '0 : {{(OW-15){y_q[14]}}, y_q};

  always_comb begin
    unique case (state_q)
      ST_SQX:  mul_a = {{(OW-15){x_q[14]}}, x_q};
      ST_SQY:  mul_a = {{(OW-15){y_q[14]}}, y_q};
      ST_SQZ:  mul_a = {{(OW-15){z_q[14]}}, z_q};
      ST_SQL:  mul_a = $signed({3'b0, l2});
      ST_H2:   mul_a = h_cur;
      ST_X2:   mul_a = x_cur;
      ST_D2:   mul_a = $signed({2'b0, d_q});
      default: mul_a = '0;
    endcase
  end
  assign prod   = mul_a * mul_a;
  assign prod_u = prod[33:0];

  always_comb begin
    unique case (state_q)
      ST_ATHP2: begin
        cord_y = $signed({2'b0, r_q});
        cord_x = $signed({2'b0, d_q});
      end
      ST_AT1: begin
        cord_y = x_cur;
        cord_x = h_cur;
      end
      ST_AT2: begin
        cord_y = ah;
        cord_x = x_cur;
      end
      ST_AT3: begin
        cord_y = y_cur;
        cord_x = h_cur;
      end
      default: begin
        cord_y = '0;
        cord_x = '0;
      end
    endcase
  end

  assign cord_start = !launched_q && (state_q == ST_ATHP2 || state_q == ST_AT1 ||
                                      state_q == ST_AT2 || state_q == ST_AT3);
  assign sq_start   = !launched_q && (state_q == ST_SQRTD || state_q == ST_SQRTR);
  assign sq_rad     = (state_q == ST_SQRTR) ? (32'(l2sq_q) - acc_q[31:0]) : acc_q[31:0];

  lik_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  lik_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (cord_y),
    .x_i     (cord_x),
    .done_o  (cord_done),
    .angle_o (cord_ang)
  );

  // pose selection: swing side takes the target solve, support side the offset pose
  assign y_neg  = y_q[14];
  assign y_zero = (y_q == '0);
  always_comb begin
    l_hp = (y_neg) ? thp_q : ihp_q;
    l_ap = (y_neg) ? tap_q : iap_q;
    r_hp = (!y_neg && !y_zero) ? thp_q : ihp_q;
    r_ap = (!y_neg && !y_zero) ? tap_q : iap_q;
    roll = y_zero ? iro_q : tro_q;
    c0   = HALF + roll;
    c1   = l_ap - HALF;
    c2   = AB'(0) - (l_hp + HALF);
    c6   = AB'(0) - (r_ap - HALF);
    c7   = r_hp + HALF;
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign out_last = err_q || (cnt_q == CNT_W'(lik_pkg::JOINTS - 1));

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.joint_index = err_q ? 4'd0 : 4'(cnt_q);
  assign out_o.position    = err_q ? '0 : stored_q[cnt_q];
  assign out_o.range_error = err_q;
  assign out_o.last        = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leg_q   <= lik_pkg::LEG_LENGTH_RST;
      lift_q  <= lik_pkg::LIFT_OFFSET_RST;
      yaw_q   <= lik_pkg::HEAD_RST;
      pitch_q <= lik_pkg::HEAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lik_pkg::CFG_LEG_LENGTH:  leg_q   <= cfg_data_i[9:0];
        lik_pkg::CFG_LIFT_OFFSET: lift_q  <= cfg_data_i[7:0];
        lik_pkg::CFG_YAW_POS:     yaw_q   <= cfg_data_i;
        lik_pkg::CFG_PITCH_POS:   pitch_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pass_q     <= 1'b0;
      err_q      <= 1'b0;
      launched_q <= 1'b0;
      cnt_q      <= '0;
      for (int k = 0; k < lik_pkg::JOINTS; k++) begin
        stored_q[k] <= (k < 10) ? lik_pkg::LEG_REST_COUNT : lik_pkg::HEAD_RST;
      end
    end else begin
      launched_q <= (launched_q || cord_start || sq_start) && !(cord_done || sq_done);
      unique case (state_q)
        ST_IDLE:  if (in_acc) state_q <= ST_SQX;
        ST_SQX:   state_q <= ST_SQY;
        ST_SQY:   state_q <= ST_SQZ;
        ST_SQZ:   state_q <= ST_SQL;
        ST_SQL:   state_q <= ST_CHECK;
        ST_CHECK: begin
          cnt_q  <= '0;
          pass_q <= 1'b0;
          if (acc_q > {4'b0, l2sq_q}) begin
            err_q   <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            err_q   <= 1'b0;
            state_q <= ST_H2;
          end
        end
        ST_H2:    state_q <= ST_X2;
        ST_X2:    state_q <= ST_SQRTD;
        ST_SQRTD: if (sq_done) state_q <= ST_D2;
        ST_D2:    state_q <= (d_q < {1'b0, l2}) ? ST_SQRTR : ST_AT1;
        ST_SQRTR: if (sq_done) state_q <= ST_ATHP2;
        ST_ATHP2: if (cord_done) state_q <= ST_AT1;
        ST_AT1:   if (cord_done) state_q <= ST_AT2;
        ST_AT2:   if (cord_done) state_q <= pass_q ? ST_WRITE : ST_AT3;
        ST_AT3: begin
          if (cord_done) begin
            pass_q  <= 1'b1;
            state_q <= ST_H2;
          end
        end
        ST_WRITE: begin
          if (!y_zero || zz_t != '0) begin
            stored_q[0] <= c0[AB-1 -: CB];
            stored_q[1] <= c1[AB-1 -: CB];
            stored_q[2] <= c2[AB-1 -: CB];
            stored_q[3] <= c0[AB-1 -: CB];
            if (!y_neg) stored_q[4] <= lik_pkg::LEG_REST_COUNT;
            stored_q[5] <= c0[AB-1 -: CB];
            stored_q[6] <= c6[AB-1 -: CB];
            stored_q[7] <= c7[AB-1 -: CB];
            stored_q[8] <= c0[AB-1 -: CB];
            stored_q[9] <= lik_pkg::LEG_REST_COUNT;
          end
          stored_q[10] <= yaw_q;
          stored_q[11] <= pitch_q;
          cnt_q        <= '0;
          state_q      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_acc) begin
            if (out_last) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_q <= in_i.x_pos;
          y_q <= in_i.y_pos;
          z_q <= in_i.z_pos;
        end
      end
      ST_SQX, ST_H2: acc_q <= prod_u;
      ST_SQY, ST_SQZ, ST_X2: acc_q <= acc_q + prod_u;
      ST_SQL: l2sq_q <= prod_u[29:0];
      ST_SQRTD: if (sq_done) d_q <= sq_root;
      ST_D2: begin
        acc_q <= prod_u;
        if (d_q >= {1'b0, l2}) hp2_q <= '0;
      end
      ST_SQRTR: if (sq_done) r_q <= sq_root;
      ST_ATHP2: if (cord_done) hp2_q <= cord_ang;
      ST_AT1:   if (cord_done) a1_q <= cord_ang;
      ST_AT2: begin
        if (cord_done) begin
          if (pass_q) begin
            ihp_q <= a1_q + hp2_q;
            iap_q <= cord_ang + hp2_q - QUARTER;
            iro_q <= a1_q;
          end else begin
            thp_q <= a1_q + hp2_q;
            tap_q <= cord_ang + hp2_q - QUARTER;
          end
        end
      end
      ST_AT3: if (cord_done) tro_q <= cord_ang;
      default: ;
    endcase
  end

`include "leg_ik_servo_targets_unit_defines.svh"

`LIK_ASSERT(a_no_overlap, !(in_i.ready && out_o.valid), "input taken while results pending")
`LIK_ASSERT(a_err_single,
            !(out_o.valid && out_o.range_error) || (out_o.last && out_o.position == '0),
            "error result malformed")
`LIK_ASSERT_NEXT(a_busy_after_in, in_i.valid && in_i.ready, !in_i.ready,
                 "unit ready right after a transaction")
`LIK_ASSERT_NEXT(a_idle_after_last, out_o.valid && out_o.ready && out_o.last, in_i.ready,
                 "unit not idle after last result")

endmodule
`default_nettype wire

### tb/lik_servo_checker.sv
`timescale 1ns / 100ps
// Checker for the leg IK servo target unit: watches the config port and both channels,
// predicts the servo counts of every foot target and compares. Depends on lik_pkg, lik_if.
module lik_servo_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lik_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [lik_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  lik_in_if                                  in_ch,
  lik_out_if                                 out_ch,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import lik_pkg::*;

  typedef struct packed {
    logic [3:0]            joint;
    logic [COUNT_BITS-1:0] pos;
    logic                  err;
    logic                  last;
  } servo_cmd_t;

  localparam bit [31:0] TURN    = (32'd1 << ANGLE_BITS) - 1;
  localparam bit [31:0] HALF    = 32'd1 << (ANGLE_BITS - 1);
  localparam bit [31:0] QUARTER = 32'd1 << (ANGLE_BITS - 2);

  logic [9:0]            leg_len;
  logic [7:0]            lift;
  logic [COUNT_BITS-1:0] neck_pan, neck_tilt;
  logic [COUNT_BITS-1:0] servo_mem [JOINTS];
  servo_cmd_t            cmd_q [$];
  int                    fails;

  assign fail_count_o = fails;
  assign pending_o    = cmd_q.size();

  function automatic bit [31:0] vec_angle(longint yv, longint xv);
    bit [31:0] ang;
    bit [31:0] stp;
    longint    xs, ys;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    xv = xv * 256;
    yv = yv * 256;
    if (xv < 0) begin
      xv  = -xv;
      yv  = -yv;
      ang = HALF;
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      stp = (ATAN_TABLE[i] + (32'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
      xs  = xv >>> i;
      ys  = yv >>> i;
      if (yv >= 0) begin
        xv += ys; yv -= xs; ang += stp;
      end else begin
        xv -= ys; yv += xs; ang -= stp;
      end
    end
    return ang & TURN;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic leg_solve(input longint x, input longint y, input longint zz,
                           input longint l2, output bit [31:0] hip,
                           output bit [31:0] ankle, output bit [31:0] roll);
    longint          h, ah;
    longint unsigned d, r;
    bit [31:0]       knee_half;
    h  = l2 - zz;
    ah = (h < 0) ? -h : h;
    d  = int_sqrt(h * h + x * x);
    knee_half = 0;
    if (d < l2) begin
      r = int_sqrt(l2 * l2 - d * d);
      knee_half = vec_angle(r, d);
    end
    hip   = (vec_angle(x, h) + knee_half) & TURN;
    ankle = (vec_angle(ah, x) + knee_half - QUARTER) & TURN;
    roll  = vec_angle(y, h);
  endtask

  function automatic logic [11:0] to_servo(bit [31:0] a);
    return 12'((a & TURN) >> (ANGLE_BITS - 12));
  endfunction

  task automatic predict_targets(input longint x, input longint y, input longint z);
    longint         l2, off, zz;
    bit [31:0]      thp, tap, tro, ihp, iap, iro;
    logic [11:0]    p [JOINTS];
    servo_cmd_t     c;
    l2  = 32 * longint'(leg_len);
    off = 16 * longint'(lift);
    zz  = z + off;
    if (x * x + y * y + z * z > l2 * l2) begin
      c = '{joint: 4'd0, pos: '0, err: 1'b1, last: 1'b1};
      cmd_q.push_back(c);
      return;
    end
    leg_solve(x, y, zz, l2, thp, tap, tro);
    leg_solve(0, 0, off, l2, ihp, iap, iro);
    if (y == 0 && zz == 0) begin
      for (int k = 0; k < 10; k++) p[k] = servo_mem[k];
    end else begin
      if (y == 0) begin
        thp = ihp; tap = iap; tro = iro;
      end
      p[0] = to_servo(HALF + tro);
      p[3] = p[0]; p[5] = p[0]; p[8] = p[0];
      p[9] = LEG_REST_COUNT;
      if (y >= 0) begin
        p[1] = to_servo(iap - HALF);
        p[2] = to_servo(0 - (ihp + HALF));
        p[4] = LEG_REST_COUNT;
        p[6] = to_servo(0 - (tap - HALF));
        p[7] = to_servo(thp + HALF);
      end else begin
        p[1] = to_servo(tap - HALF);
        p[2] = to_servo(0 - (thp + HALF));
        p[4] = servo_mem[4];
        p[6] = to_servo(0 - (iap - HALF));
        p[7] = to_servo(ihp + HALF);
      end
    end
    p[10] = neck_pan;
    p[11] = neck_tilt;
    for (int k = 0; k < JOINTS; k++) begin
      servo_mem[k] = p[k];
      c = '{joint: 4'(k), pos: p[k], err: 1'b0, last: (k == JOINTS - 1)};
      cmd_q.push_back(c);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    servo_cmd_t want, got;
    if (!rst_ni) begin
      leg_len   = LEG_LENGTH_RST;
      lift      = LIFT_OFFSET_RST;
      neck_pan  = HEAD_RST;
      neck_tilt = HEAD_RST;
      for (int k = 0; k < JOINTS; k++) servo_mem[k] = (k < 10) ? LEG_REST_COUNT : HEAD_RST;
      cmd_q.delete();
      fails = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{joint: out_ch.joint_index, pos: out_ch.position,
                err: out_ch.range_error, last: out_ch.last};
        if (cmd_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected transaction: joint %0d pos %0d err %0b last %0b",
                                    got.joint, got.pos, got.err, got.last);
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp joint %0d pos %0d err %0b last %0b, got %0d %0d %0b %0b",
                       want.joint, want.pos, want.err, want.last,
                       got.joint, got.pos, got.err, got.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_targets(longint'(in_ch.x_pos), longint'(in_ch.y_pos), longint'(in_ch.z_pos));
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LEG_LENGTH:  leg_len   = cfg_data_i[9:0];
          CFG_LIFT_OFFSET: lift      = cfg_data_i[7:0];
          CFG_YAW_POS:     neck_pan  = cfg_data_i;
          CFG_PITCH_POS:   neck_tilt = cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the leg IK servo target testbench: clock, reset, config writes, foot target
// stimulus and receiver stalls. Depends on lik_pkg, lik_if, lik_servo_checker and the unit.
module tb_top;
  import lik_pkg::*;

  logic                     clk_i, rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       fail_count, pending;
  int                       tx_idle, rx_idle, sent;
  bit                       rx_hold;
  logic [9:0]               cur_len;
  logic [7:0]               cur_lift;
  longint                   cycles;

  lik_in_if  in_ch ();
  lik_out_if out_ch ();

  leg_ik_servo_targets_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_i(in_ch), .out_o(out_ch)
  );

  lik_servo_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 3000000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(negedge clk_i)
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle);

  initial begin
    wait (sent >= 60);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (700) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_BITS'(val);
    if (idx == CFG_LEG_LENGTH) cur_len = 10'(val);
    if (idx == CFG_LIFT_OFFSET) cur_lift = 8'(val);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(input int len, input int lift, input int yaw, input int pitch);
    wait (pending == 0);
    repeat (300) @(negedge clk_i);
    write_reg(CFG_LEG_LENGTH, len);
    write_reg(CFG_LIFT_OFFSET, lift);
    write_reg(CFG_YAW_POS, yaw);
    write_reg(CFG_PITCH_POS, pitch);
  endtask

  task automatic send_target(input int x, input int y, input int z);
    while ($urandom_range(99) < tx_idle) @(negedge clk_i);
    in_ch.x_pos = COORD_BITS'(x);
    in_ch.y_pos = COORD_BITS'(y);
    in_ch.z_pos = COORD_BITS'(z);
    in_ch.valid = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  function automatic int span(int m);
    return $urandom_range(2 * m) - m;
  endfunction

  task automatic random_target();
    int m, x, y, z, sel;
    m   = cur_len * 16;
    sel = $urandom_range(99);
    x   = span(m);
    y   = span(m);
    z   = span(m);
    if (sel < 20) begin
      x = $urandom_range(32767) - 16384;
      y = $urandom_range(32767) - 16384;
      z = $urandom_range(32767) - 16384;
    end else if (sel < 32) begin
      y = 0;
    end else if (sel < 38) begin
      y = 0;
      z = -16 * cur_lift;
    end
    send_target(x, y, z);
    sent++;
    tx_idle = (sent < 140) ? 18 : (sent < 280) ? 86 : 0;
    rx_idle = (sent < 140) ? 86 : (sent < 280) ? 18 : 0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.x_pos  = '0;
    in_ch.y_pos  = '0;
    in_ch.z_pos  = '0;
    out_ch.ready = 1'b0;
    rx_hold      = 1'b0;
    sent         = 0;
    tx_idle      = 18;
    rx_idle      = 86;
    cur_len      = LEG_LENGTH_RST;
    cur_lift     = LIFT_OFFSET_RST;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_target(0, 0, 0);
    send_target(0, 0, -320);
    send_target(0, 0, -320);
    send_target(16383, 16383, 16383);
    send_target(-16384, -16384, -16384);
    send_target(5760, 0, 0);
    send_target(5761, 0, 0);
    send_target(0, 0, -5760);
    send_target(0, 0, 5760);
    send_target(-5000, 1000, 200);
    send_target(1200, 900, -400);
    send_target(1200, -900, -400);
    send_target(-800, -2500, 1500);
    send_target(0, 0, -320);
    send_target(700, 0, 600);
    send_target(0, 1, 0);
    send_target(0, -1, 0);

    set_regs(1023, 255, 0, 4095);
    send_target(16383, 0, 0);
    send_target(-16384, 16383, -4080);
    send_target(0, 0, -4080);
    repeat (100) random_target();
    set_regs(1, 0, 4095, 0);
    send_target(0, 0, 0);
    send_target(32, 0, 0);
    repeat (100) random_target();
    set_regs(0, 255, 1234, 2345);
    send_target(0, 0, 0);
    send_target(1, 0, 0);
    repeat (20) random_target();
    set_regs(180, 20, 512, 512);
    repeat (100) random_target();
    set_regs($urandom_range(1, 1023), $urandom_range(255), $urandom_range(4095),
             $urandom_range(4095));
    repeat (100) random_target();

    wait (pending == 0);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
